// ===== src/nte_pkg.sv =====
// ----------------------------------------------------------------------------
// N-gram token emitter package
// Shared widths, controller states and the command and status words that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nte_pkg;

  // Field widths.
  localparam int CNT_W   = 4;
  localparam int BYTES_W = 3;
  localparam int OFF_W   = 32;
  localparam int LEN_W   = 6;

  // Upper limit on the n-gram length in characters, whatever the window depth.
  localparam int GRAM_LIMIT = 8;

  // Configuration register indexes.
  localparam logic [0:0] CFG_MIN_GRAM = 1'b0;
  localparam logic [0:0] CFG_MAX_GRAM = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_PRE,
    S_APPEND,
    S_POST,
    S_FLUSH,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start_item;  // input word accepted this cycle
    logic emit_gram;   // load the current n-gram into the output register
    logic emit_done;   // load the end-of-text marker into the output register
    logic last;        // the word being loaded is the item's last result
    logic clear;       // empty the window
    logic append;      // store the held character in the window
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic item_end;           // held item ends the text
    logic item_word;          // held item is a word character
    logic fill_ge_min;        // window holds at least the effective min
    logic fill_ge_max;        // window holds at least the effective max
    logic fill_gt_min;        // more groups remain in a flush after this one
    logic fill_gt_max;        // another group is due before the append
    logic post_after_append;  // the append brings the window up to the effective max
    logic n_is_hi;            // current n-gram is the last of its group
    logic out_free;           // output register can take a word this cycle
  } stat_t;

endpackage

`default_nettype wire

// ===== src/nte_ctrl.sv =====
// ----------------------------------------------------------------------------
// N-gram token emitter controller
// Sequences one input item: decode, pre-append groups, append, post-append
// group, window flush and the end-of-text marker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nte_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire nte_pkg::stat_t st,
  output nte_pkg::cmd_t       cmd
);
  import nte_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start_item = 1'b1;
          state_next     = S_START;
        end
      end
      S_START: begin
        if (st.item_end || !st.item_word) begin
          if (st.fill_ge_min) begin
            state_next = S_FLUSH;
          end else begin
            cmd.clear  = 1'b1;
            state_next = st.item_end ? S_DONE : S_IDLE;
          end
        end else if (st.fill_ge_max) begin
          state_next = S_PRE;
        end else begin
          state_next = S_APPEND;
        end
      end
      // Groups before the append; the post-append group always follows.
      S_PRE: begin
        if (st.out_free) begin
          cmd.emit_gram = 1'b1;
          if (st.n_is_hi) begin
            state_next = st.fill_gt_max ? S_PRE : S_APPEND;
          end
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_next = st.post_after_append ? S_POST : S_IDLE;
      end
      S_POST: begin
        if (st.out_free) begin
          cmd.emit_gram = 1'b1;
          cmd.last      = st.n_is_hi;
          if (st.n_is_hi) begin
            state_next = S_IDLE;
          end
        end
      end
      // Flush continues while the window still holds the min.
      S_FLUSH: begin
        if (st.out_free) begin
          cmd.emit_gram = 1'b1;
          if (st.n_is_hi && !st.fill_gt_min) begin
            cmd.clear  = 1'b1;
            cmd.last   = !st.item_end;
            state_next = st.item_end ? S_DONE : S_IDLE;
          end
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.emit_done = 1'b1;
          cmd.last      = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/nte_dpath.sv =====
// ----------------------------------------------------------------------------
// N-gram token emitter datapath
// Configuration registers, the character window, the running byte offset,
// the n-gram length counter and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nte_dpath #(
  parameter int RING_DEPTH = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [0:0]                   cfg_index,
  input  wire logic [nte_pkg::CNT_W-1:0]    cfg_data,
  input  wire logic [nte_pkg::BYTES_W-1:0]  char_bytes,
  input  wire logic                         is_word_char,
  input  wire logic                         end_of_text,
  input  wire nte_pkg::cmd_t                cmd,
  output nte_pkg::stat_t                    st,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [nte_pkg::OFF_W-1:0]         start_offset,
  output logic [nte_pkg::LEN_W-1:0]         byte_length,
  output logic [nte_pkg::CNT_W-1:0]         char_count,
  output logic                              text_done,
  output logic                              last
);
  import nte_pkg::*;

  localparam int GRAM_CAP = (RING_DEPTH < GRAM_LIMIT) ? RING_DEPTH : GRAM_LIMIT;

  logic [CNT_W-1:0]   min_gram;
  logic [CNT_W-1:0]   max_gram;
  logic [CNT_W-1:0]   eff_min;
  logic [CNT_W-1:0]   eff_max;
  logic [CNT_W-1:0]   hi;
  logic [CNT_W-1:0]   fill;
  logic [CNT_W-1:0]   gram_n;
  logic [OFF_W-1:0]   text_offset;
  logic [BYTES_W-1:0] item_bytes;
  logic               item_end;
  logic               item_word;
  logic [OFF_W-1:0]   ent_off [GRAM_CAP];
  logic [BYTES_W-1:0] ent_len [GRAM_CAP];
  logic [LEN_W-1:0]   gram_sum;
  logic               drop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_gram <= CNT_W'(2);
      max_gram <= CNT_W'(3);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_GRAM: min_gram <= cfg_data;
        CFG_MAX_GRAM: max_gram <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp max to 1..GRAM_CAP and min to 1..max.
  always_comb begin
    if (max_gram == '0) begin
      eff_max = CNT_W'(1);
    end else if (max_gram > CNT_W'(GRAM_CAP)) begin
      eff_max = CNT_W'(GRAM_CAP);
    end else begin
      eff_max = max_gram;
    end
    if (min_gram == '0) begin
      eff_min = CNT_W'(1);
    end else if (min_gram > eff_max) begin
      eff_min = eff_max;
    end else begin
      eff_min = min_gram;
    end
    hi = (fill < eff_max) ? fill : eff_max;
  end

  // Held item and running byte offset. A word character advances the
  // offset when it is stored; a delimiter advances it at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      text_offset <= '0;
      item_end    <= 1'b0;
      item_word   <= 1'b0;
      item_bytes  <= '0;
    end else if (cmd.start_item) begin
      item_bytes <= char_bytes;
      item_end   <= end_of_text || (char_bytes == '0);
      item_word  <= is_word_char;
      if (end_of_text || (char_bytes == '0)) begin
        text_offset <= '0;
      end else if (!is_word_char) begin
        text_offset <= text_offset + OFF_W'(char_bytes);
      end
    end else if (cmd.append) begin
      text_offset <= text_offset + OFF_W'(item_bytes);
    end
  end

  // The oldest character is dropped after the last n-gram of its group.
  assign drop = cmd.emit_gram && (gram_n == hi);

  // Window fill and n-gram length counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      gram_n <= CNT_W'(1);
    end else begin
      if (cmd.clear) begin
        fill <= '0;
      end else if (drop) begin
        fill <= fill - CNT_W'(1);
      end else if (cmd.append) begin
        fill <= fill + CNT_W'(1);
      end
      if (cmd.start_item || drop) begin
        gram_n <= eff_min;
      end else if (cmd.emit_gram) begin
        gram_n <= gram_n + CNT_W'(1);
      end
    end
  end

  // Window entries: entry 0 is the oldest character; a drop shifts down.
  for (genvar k = 0; k < GRAM_CAP; k++) begin : g_ent
    logic [OFF_W-1:0]   off_src;
    logic [BYTES_W-1:0] len_src;
    if (k < GRAM_CAP - 1) begin : g_mid
      assign off_src = ent_off[k+1];
      assign len_src = ent_len[k+1];
    end else begin : g_top
      assign off_src = ent_off[k];
      assign len_src = ent_len[k];
    end
    always_ff @(posedge clk) begin
      if (drop) begin
        ent_off[k] <= off_src;
        ent_len[k] <= len_src;
      end else if (cmd.append && (fill == CNT_W'(k))) begin
        ent_off[k] <= text_offset;
        ent_len[k] <= item_bytes;
      end
    end
  end

  // Byte length of the n-gram of gram_n characters at the oldest entry.
  always_comb begin
    gram_sum = '0;
    for (int k = 0; k < GRAM_CAP; k++) begin
      if (CNT_W'(k) < gram_n) begin
        gram_sum = gram_sum + LEN_W'(ent_len[k]);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_gram || cmd.emit_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_gram) begin
      start_offset <= ent_off[0];
      byte_length  <= gram_sum;
      char_count   <= gram_n;
      text_done    <= 1'b0;
      last         <= cmd.last;
    end else if (cmd.emit_done) begin
      start_offset <= '0;
      byte_length  <= '0;
      char_count   <= '0;
      text_done    <= 1'b1;
      last         <= 1'b1;
    end
  end

  // Status to the controller.
  always_comb begin
    st.item_end          = item_end;
    st.item_word         = item_word;
    st.fill_ge_min       = fill >= eff_min;
    st.fill_ge_max       = fill >= eff_max;
    st.fill_gt_min       = fill > eff_min;
    st.fill_gt_max       = fill > eff_max;
    st.post_after_append = (fill + CNT_W'(1)) >= eff_max;
    st.n_is_hi           = gram_n == hi;
    st.out_free          = !out_valid || out_ready;
  end

  // A result is only loaded when the output register can take it.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_gram || cmd.emit_done) |-> st.out_free)
    else $error("result loaded while the output register is held");

  // An n-gram never reaches past the characters held in the window.
  a_gram_in_fill: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_gram |-> (gram_n != '0) && (gram_n <= fill))
    else $error("n-gram length outside the window fill");

  // A character is never stored into a full window.
  a_append_room: assert property (@(posedge clk) disable iff (rst)
    cmd.append |-> (fill < CNT_W'(GRAM_CAP)))
    else $error("append into a full window");

  // The end-of-text marker always closes its item.
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && text_done) |-> last)
    else $error("end-of-text marker without last");

endmodule

`default_nettype wire

// ===== src/ngram_token_emitter.sv =====
// ----------------------------------------------------------------------------
// N-gram token emitter
// Turns a stream of decoded characters into character n-gram tokens.
// ----------------------------------------------------------------------------
// Each input word is one decoded character or an end-of-text mark. The block
// holds up to min(RING_DEPTH, 8) word characters; whenever the window reaches
// max_gram characters it emits every n-gram of min_gram..max_gram characters
// that starts at the oldest character and drops that character. A delimiter
// flushes the window; end of text (or a zero byte length) flushes it, emits a
// marker word with text_done set and restarts the byte offset at zero. Items
// are handled one at a time by a state machine: an item is accepted, then
// decoded and, for a word character, stored in the window; result words go
// out at one word per cycle while the output side is ready. That result rate
// is set by the single output register. The next item is accepted while the
// last result of the previous one still waits in that register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ngram_token_emitter #(
  parameter int RING_DEPTH = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // Configuration.
  input  wire logic                         cfg_we,
  input  wire logic [0:0]                   cfg_index,
  input  wire logic [nte_pkg::CNT_W-1:0]    cfg_data,
  // Input characters.
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [nte_pkg::BYTES_W-1:0]  char_bytes,
  input  wire logic                         is_word_char,
  input  wire logic                         end_of_text,
  // Output tokens.
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [nte_pkg::OFF_W-1:0]         start_offset,
  output logic [nte_pkg::LEN_W-1:0]         byte_length,
  output logic [nte_pkg::CNT_W-1:0]         char_count,
  output logic                              text_done,
  output logic                              last
);
  import nte_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // Sequencer.
  nte_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Window, offsets and output register.
  nte_dpath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .char_bytes   (char_bytes),
    .is_word_char (is_word_char),
    .end_of_text  (end_of_text),
    .cmd          (cmd),
    .st           (st),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .start_offset (start_offset),
    .byte_length  (byte_length),
    .char_count   (char_count),
    .text_done    (text_done),
    .last         (last)
  );

endmodule

`default_nettype wire

// ===== tb/tb_ngram_token_emitter.sv =====
// ----------------------------------------------------------------------------
// N-gram token emitter testbench
// Feeds the emitter decoded characters and end-of-text marks and sweeps the
// gram limits, clamped values among them. A scoreboard predicts every token
// word and checks the output words in order, field by field. Both sides idle
// and stall at random in several phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ngram_token_emitter;
  import nte_pkg::*;

  localparam int WIN_DEPTH   = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_CYCLES = 16;
  localparam int TAIL_CYCLES = 24;

  // One output token word.
  typedef struct packed {
    logic [OFF_W-1:0] offset;
    logic [LEN_W-1:0] nbytes;
    logic [CNT_W-1:0] nchars;
    logic             done;
    logic             lst;
  } token_t;

  // Tracks the window and the running offset, and holds the tokens that are
  // still due from the block.
  class token_scoreboard;
    logic [CNT_W-1:0]   min_reg;
    logic [CNT_W-1:0]   max_reg;
    logic [OFF_W-1:0]   char_off [WIN_DEPTH];
    logic [BYTES_W-1:0] char_len [WIN_DEPTH];
    int unsigned        head;
    int unsigned        fill;
    logic [OFF_W-1:0]   text_pos;
    token_t             due_tokens[$];
    token_t             burst[$];
    int                 errors;
    int                 chars_in;
    int                 tokens_out;
    int                 done_marks;
    int                 widest_burst;

    function new();
      min_reg      = 4'd2;
      max_reg      = 4'd3;
      head         = 0;
      fill         = 0;
      text_pos     = '0;
      errors       = 0;
      chars_in     = 0;
      tokens_out   = 0;
      done_marks   = 0;
      widest_burst = 0;
    endfunction

    function void write_reg(logic [0:0] idx, logic [CNT_W-1:0] value);
      if (idx == CFG_MIN_GRAM) min_reg = value;
      else max_reg = value;
    endfunction

    function int pending();
      return due_tokens.size();
    endfunction

    // Largest gram after clamping to the window.
    function int unsigned gram_hi();
      int unsigned m;
      m = max_reg;
      if (m < 1) m = 1;
      if (m > GRAM_LIMIT) m = GRAM_LIMIT;
      if (m > WIN_DEPTH) m = WIN_DEPTH;
      return m;
    endfunction

    // Smallest gram, never above the largest.
    function int unsigned gram_lo();
      int unsigned m;
      int unsigned hi;
      m  = min_reg;
      hi = gram_hi();
      if (m < 1) m = 1;
      if (m > hi) m = hi;
      return m;
    endfunction

    // All grams that start at the oldest character, then drop it.
    function void emit_oldest();
      int unsigned lo;
      int unsigned hi;
      int unsigned sum;
      token_t      tok;
      lo = gram_lo();
      hi = gram_hi();
      if (hi > fill) hi = fill;
      for (int unsigned n = lo; n <= hi; n++) begin
        sum = 0;
        for (int unsigned i = 0; i < n; i++)
          sum += char_len[(head + i) % WIN_DEPTH];
        tok.offset = char_off[head];
        tok.nbytes = LEN_W'(sum);
        tok.nchars = CNT_W'(n);
        tok.done   = 1'b0;
        tok.lst    = 1'b0;
        burst.push_back(tok);
      end
      head = (head + 1) % WIN_DEPTH;
      if (fill > 0) fill--;
    endfunction

    function void flush_window();
      while (fill >= gram_lo() && fill > 0) emit_oldest();
      fill = 0;
      head = 0;
    endfunction

    // Works out the tokens caused by one accepted character word.
    function void note_char(logic [BYTES_W-1:0] nb, logic word, logic eot);
      token_t      tok;
      int unsigned slot;
      burst.delete();
      chars_in++;
      if (eot || nb == '0) begin
        flush_window();
        tok = '0;
        tok.done = 1'b1;
        burst.push_back(tok);
        text_pos = '0;
      end else if (!word) begin
        flush_window();
        text_pos = text_pos + OFF_W'(nb);
      end else begin
        // A lowered max may leave the window over full: drain it first.
        while (fill >= gram_hi()) emit_oldest();
        slot = (head + fill) % WIN_DEPTH;
        char_off[slot] = text_pos;
        char_len[slot] = nb;
        fill++;
        text_pos = text_pos + OFF_W'(nb);
        if (fill >= gram_hi()) emit_oldest();
      end
      if (burst.size() > 0) begin
        tok = burst[burst.size() - 1];
        tok.lst = 1'b1;
        burst[burst.size() - 1] = tok;
      end
      if (burst.size() > widest_burst) widest_burst = burst.size();
      foreach (burst[i]) due_tokens.push_back(burst[i]);
    endfunction

    // Compares one output token word with the oldest one due.
    function void check_token(token_t got);
      token_t want;
      tokens_out++;
      if (got.done) done_marks++;
      if (due_tokens.size() == 0) begin
        errors++;
        $display("%0t: unexpected token off=%0d bytes=%0d chars=%0d done=%0b last=%0b",
                 $time, got.offset, got.nbytes, got.nchars, got.done, got.lst);
        return;
      end
      want = due_tokens.pop_front();
      if (got != want) begin
        errors++;
        $display("%0t: token mismatch: expected off=%0d bytes=%0d chars=%0d done=%0b last=%0b",
                 $time, want.offset, want.nbytes, want.nchars, want.done, want.lst);
        $display("%0t:                 actual   off=%0d bytes=%0d chars=%0d done=%0b last=%0b",
                 $time, got.offset, got.nbytes, got.nchars, got.done, got.lst);
      end
    endfunction

    function void finish();
      if (due_tokens.size() != 0) begin
        errors++;
        $display("%0t: %0d expected tokens never arrived", $time, due_tokens.size());
      end
    endfunction
  endclass

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               cfg_we       = 1'b0;
  logic [0:0]         cfg_index    = CFG_MIN_GRAM;
  logic [CNT_W-1:0]   cfg_data     = '0;
  logic               in_valid     = 1'b0;
  logic               in_ready;
  logic [BYTES_W-1:0] char_bytes   = '0;
  logic               is_word_char = 1'b0;
  logic               end_of_text  = 1'b0;
  logic               out_valid;
  logic               out_ready    = 1'b0;
  logic [OFF_W-1:0]   start_offset;
  logic [LEN_W-1:0]   byte_length;
  logic [CNT_W-1:0]   char_count;
  logic               text_done;
  logic               last;

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int unsigned cycles         = 0;

  token_scoreboard sb = new();

  ngram_token_emitter u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_bytes   (char_bytes),
    .is_word_char (is_word_char),
    .end_of_text  (end_of_text),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .start_offset (start_offset),
    .byte_length  (byte_length),
    .char_count   (char_count),
    .text_done    (text_done),
    .last         (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d tokens outstanding", $time, sb.pending());
      $display("FAILURE");
      $finish;
    end
  end

  // Random receiver stalls.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Every accepted word on either side goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_char(char_bytes, is_word_char, end_of_text);
      if (out_valid && out_ready)
        sb.check_token(token_t'({start_offset, byte_length, char_count, text_done, last}));
    end
  end

  // Sends one character word, with a random gap in front of it.
  task automatic send_char(input logic [BYTES_W-1:0] nb, input logic word, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    char_bytes   <= nb;
    is_word_char <= word;
    end_of_text  <= eot;
    do @(posedge clk); while (!in_ready);
  endtask

  // Holds the input off until every due token has come out.
  task automatic wait_idle(input int extra);
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (extra) @(posedge clk);
  endtask

  // Writes both gram limits; the block must be idle.
  task automatic set_gram_limits(input logic [CNT_W-1:0] mn, input logic [CNT_W-1:0] mx);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MIN_GRAM;
    cfg_data  <= mn;
    @(posedge clk);
    sb.write_reg(CFG_MIN_GRAM, mn);
    cfg_index <= CFG_MAX_GRAM;
    cfg_data  <= mx;
    @(posedge clk);
    sb.write_reg(CFG_MAX_GRAM, mx);
    cfg_we <= 1'b0;
  endtask

  // Mostly runs of word characters split by delimiters, with end marks,
  // invalid and oversized characters mixed in. Halfway through, the sender
  // waits for the output to drain.
  task automatic random_text(input int count);
    int unsigned pick;
    for (int k = 0; k < count; k++) begin
      if (k == count / 2) wait_idle(0);
      pick = $urandom_range(99);
      if (pick < 66)
        send_char(BYTES_W'($urandom_range(4, 1)), 1'b1, 1'b0);
      else if (pick < 84)
        send_char(BYTES_W'($urandom_range(4, 1)), 1'b0, 1'b0);
      else if (pick < 91)
        send_char(BYTES_W'($urandom_range(7, 0)), 1'($urandom_range(1)), 1'b1);
      else if (pick < 95)
        send_char('0, 1'($urandom_range(1)), 1'b0);
      else
        send_char(BYTES_W'($urandom_range(7, 5)), 1'($urandom_range(1)), 1'b0);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset limits (min 2, max 3): fill the window, slide it, flush it.
    send_char(3'd1, 1'b1, 1'b0);
    send_char(3'd4, 1'b1, 1'b0);
    send_char(3'd2, 1'b1, 1'b0);
    send_char(3'd3, 1'b1, 1'b0);
    send_char(3'd1, 1'b0, 1'b0);
    // Oversized characters count at face value.
    send_char(3'd7, 1'b1, 1'b0);
    send_char(3'd5, 1'b1, 1'b0);
    send_char(3'd6, 1'b1, 1'b0);
    // The end mark wins over a word character in the same word.
    send_char(3'd3, 1'b1, 1'b1);
    // A zero byte length ends the text as well.
    send_char(3'd2, 1'b1, 1'b0);
    send_char(3'd0, 1'b1, 1'b0);
    // A delimiter on an empty window produces nothing.
    send_char(3'd4, 1'b0, 1'b0);
    wait_idle(IDLE_CYCLES);

    // Widest burst: seven characters in an eight wide window, then the end.
    set_gram_limits(4'd1, 4'd8);
    for (int k = 0; k < 7; k++)
      send_char((k == 2) ? 3'd7 : BYTES_W'(k % 4 + 1), 1'b1, 1'b0);
    send_char(3'd0, 1'b0, 1'b1);

    // Max lowered while the window still holds five characters.
    repeat (5) send_char(3'd2, 1'b1, 1'b0);
    wait_idle(IDLE_CYCLES);
    set_gram_limits(4'd1, 4'd2);
    send_char(3'd1, 1'b1, 1'b0);
    send_char(3'd4, 1'b0, 1'b0);
    wait_idle(IDLE_CYCLES);

    // Random phases: no idling, sender gaps, receiver stalls, then both.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
          set_gram_limits(4'd0, 4'd0);
        end
        1: begin
          send_idle_pct = 81; recv_stall_pct = 0;
          set_gram_limits(4'd15, 4'd15);
        end
        2: begin
          send_idle_pct = 0;  recv_stall_pct = 81;
          set_gram_limits(4'd3, 4'd5);
        end
        default: begin
          send_idle_pct = 24; recv_stall_pct = 24;
          set_gram_limits(4'd6, 4'd2);
        end
      endcase
      random_text(26);
      wait_idle(IDLE_CYCLES);
    end

    wait_idle(TAIL_CYCLES);
    sb.finish();
    $display("Sent %0d characters, checked %0d tokens including %0d end markers.",
             sb.chars_in, sb.tokens_out, sb.done_marks);
    $display("Gram limits swept through clamped extremes; largest burst %0d tokens, %0d errors.",
             sb.widest_burst, sb.errors);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
